@@ rtl/core/ccsi_pkg.sv @@
// ----------------------------------------------------------------------------
// ccsi_pkg
// Shared constants and types for the continuous-clock serial frame serializer.
// ----------------------------------------------------------------------------
package ccsi_pkg;

	// One unit is sent as 16 data bits plus the inverted-LSB check bit.
	localparam int WORD_W     = 16;
	localparam int UNIT_BITS  = WORD_W + 1;
	localparam int BIT_CNT_W  = $clog2(UNIT_BITS);

	// Length of the run of ones that closes a frame.
	localparam int STOP_EDGES = 18;
	localparam int STOP_CNT_W = $clog2(STOP_EDGES);

	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctrl_t;

endpackage

@@ rtl/core/ccsi_frame_serializer_top.sv @@
// ----------------------------------------------------------------------------
// ccsi_frame_serializer_top
// Turns 16-bit units with frame open/close flags into one serial level per
// result item: optional START zero, 17 unit bits, optional STOP run of ones.
// ----------------------------------------------------------------------------
// The first result of an item is registered in the START or DATA state that
// follows accept, once the output register can take it. Throughput: one
// result per cycle while out_ready is high; an item occupies the sequencer
// from accept until it returns to idle, so no new item is taken meanwhile.
// Reset: arst_n asynchronously returns the sequencer to idle with no result.
module ccsi_frame_serializer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ccsi_pkg::WORD_W-1:0] data_word,
	input  logic                        opens_frame,
	input  logic                        closes_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        sin_level,
	output logic                        run_end
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DATA,
		ST_STOP
	} state_t;

	state_t                          state_q;
	logic                            close_q;
	logic [ccsi_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic [ccsi_pkg::STOP_CNT_W-1:0] stop_cnt_q;
	logic                            out_valid_q;
	logic                            sin_q;
	logic                            run_end_q;

	logic                  in_fire;
	logic                  advance;
	logic                  last_bit;
	logic                  last_stop;
	logic                  unit_msb;
	ccsi_pkg::shift_ctrl_t shift_ctrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	// The output register can take a new result when empty or being drained.
	assign advance   = !out_valid_q || out_ready;
	assign last_bit  = (bit_cnt_q == ccsi_pkg::BIT_CNT_W'(ccsi_pkg::UNIT_BITS - 1));
	assign last_stop = (stop_cnt_q == ccsi_pkg::STOP_CNT_W'(ccsi_pkg::STOP_EDGES - 1));

	assign shift_ctrl.load  = in_fire;
	assign shift_ctrl.shift = (state_q == ST_DATA) && advance;

	ccsi_shifter u_shifter (
		.clk       (clk),
		.ctrl      (shift_ctrl),
		.data_word (data_word),
		.msb       (unit_msb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			close_q     <= 1'b0;
			bit_cnt_q   <= '0;
			stop_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			sin_q       <= 1'b0;
			run_end_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						close_q    <= closes_frame;
						bit_cnt_q  <= '0;
						stop_cnt_q <= '0;
						state_q    <= opens_frame ? ST_START : ST_DATA;
					end
				end
				ST_START: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						sin_q       <= 1'b0;
						run_end_q   <= 1'b0;
						state_q     <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						sin_q       <= unit_msb;
						run_end_q   <= last_bit && !close_q;
						bit_cnt_q   <= bit_cnt_q + 1'b1;
						if (last_bit) begin
							state_q <= close_q ? ST_STOP : ST_IDLE;
						end
					end
				end
				ST_STOP: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						sin_q       <= 1'b1;
						run_end_q   <= last_stop;
						stop_cnt_q  <= stop_cnt_q + 1'b1;
						if (last_stop) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sin_level = sin_q;
	assign run_end   = run_end_q;

	// An accepted item keeps the sequencer busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("in_ready high right after an item was accepted");

	// A stalled result must stay in place until it is taken.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(sin_q)
			&& $stable(run_end_q)))
		else $error("result changed while output stalled");

	// Every STOP run result is a one.
	a_stop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STOP && advance) |=> (out_valid_q && sin_q))
		else $error("STOP run produced a zero level");

endmodule

@@ rtl/core/ccsi_shifter.sv @@
// ----------------------------------------------------------------------------
// ccsi_shifter
// Holds one unit with its check bit and shifts it out MSB first.
// ----------------------------------------------------------------------------
module ccsi_shifter (
	input  logic                        clk,
	input  ccsi_pkg::shift_ctrl_t       ctrl,
	input  logic [ccsi_pkg::WORD_W-1:0] data_word,
	output logic                        msb
);

	logic [ccsi_pkg::UNIT_BITS-1:0] pattern_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			// The check bit is the inverse of the data LSB.
			pattern_q <= {data_word, ~data_word[0]};
		end else if (ctrl.shift) begin
			pattern_q <= {pattern_q[ccsi_pkg::UNIT_BITS-2:0], 1'b0};
		end
	end

	assign msb = pattern_q[ccsi_pkg::UNIT_BITS-1];

endmodule
